/* rtl/ebcalu_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the eight-bit alu with flags
// no dependencies; imported by ebcalu_core and the top level
package ebcalu_pkg;

    // operation codes carried in the request
    typedef enum logic [4:0] {
        OP_ADD    = 5'd0,
        OP_ADC    = 5'd1,
        OP_SUB    = 5'd2,
        OP_SBC    = 5'd3,
        OP_AND    = 5'd4,
        OP_XOR    = 5'd5,
        OP_OR     = 5'd6,
        OP_CP     = 5'd7,
        OP_INC    = 5'd8,
        OP_DEC    = 5'd9,
        OP_ADD_HL = 5'd10,
        OP_ADD_SP = 5'd11,
        OP_DAA    = 5'd12,
        OP_CPL    = 5'd13,
        OP_SCF    = 5'd14,
        OP_CCF    = 5'd15,
        OP_RLCA   = 5'd16,
        OP_RRCA   = 5'd17,
        OP_RLA    = 5'd18,
        OP_RRA    = 5'd19,
        OP_RLC    = 5'd20,
        OP_RRC    = 5'd21,
        OP_RL     = 5'd22,
        OP_RR     = 5'd23,
        OP_SLA    = 5'd24,
        OP_SRA    = 5'd25,
        OP_SWAP   = 5'd26,
        OP_SRL    = 5'd27,
        OP_BIT    = 5'd28,
        OP_SET    = 5'd29,
        OP_RES    = 5'd30
    } op_t;

    // rotate kinds, low two bits of the rotate opcodes
    localparam logic [1:0] ROT_LC = 2'd0;
    localparam logic [1:0] ROT_RC = 2'd1;
    localparam logic [1:0] ROT_L  = 2'd2;
    localparam logic [1:0] ROT_R  = 2'd3;

    // flag bit positions
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // decimal adjust constants
    localparam logic [7:0] DAA_BCD_MAX  = 8'h99;
    localparam logic [3:0] DAA_NIB_MAX  = 4'h9;
    localparam logic [7:0] DAA_LOW_FIX  = 8'h06;
    localparam logic [7:0] DAA_HIGH_FIX = 8'h60;

    localparam int TDATA_IN_W  = 64;
    localparam int TDATA_OUT_W = 40;

    typedef struct packed {
        logic [4:0]        req_type;
        logic [7:0]        acc_in;
        logic [3:0]        flags_in;
        logic [7:0]        operand_byte;
        logic [15:0]       base_word;
        logic [15:0]       addend_word;
        logic signed [7:0] offset;
        logic [2:0]        bit_index;
    } req_t;

    typedef struct packed {
        logic [7:0]  acc_out;
        logic [3:0]  flags_out;
        logic [7:0]  byte_result;
        logic [15:0] word_result;
    } res_t;

endpackage

/* rtl/ebcalu_core.sv */
`timescale 1ns / 1ps
// operation datapath: one request in, one result out, purely combinational
// depends on ebcalu_pkg
module ebcalu_core import ebcalu_pkg::*; (
    input  req_t req,
    output res_t res
);

    logic [7:0]  a;
    logic [7:0]  v;
    logic [3:0]  fi;
    logic        cin;
    logic        add_cin;
    logic        sub_cin;
    logic [8:0]  add_sum;
    logic [4:0]  add_half;
    logic [8:0]  sub_diff;
    logic [4:0]  sub_half;
    logic [7:0]  inc_val;
    logic [7:0]  dec_val;
    logic [16:0] hl_sum;
    logic [12:0] hl_half;
    logic [15:0] sp_sum;
    logic [4:0]  sp_half;
    logic [8:0]  sp_low;
    logic        daa_lo;
    logic        daa_hi;
    logic [7:0]  daa_corr;
    logic [7:0]  daa_val;
    logic [7:0]  rot_src;
    logic [7:0]  rot_val;
    logic        rot_co;
    logic [7:0]  bit_mask;

    assign a   = req.acc_in;
    assign v   = req.operand_byte;
    assign fi  = req.flags_in;
    assign cin = fi[FLAG_C];

    assign add_cin  = (req.req_type == OP_ADC) ? cin : 1'b0;
    assign sub_cin  = (req.req_type == OP_SBC) ? cin : 1'b0;
    assign add_sum  = {1'b0, a} + {1'b0, v} + {8'd0, add_cin};
    assign add_half = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, add_cin};
    // bit 8 / bit 4 of the wrapped difference is the borrow
    assign sub_diff = {1'b0, a} - {1'b0, v} - {8'd0, sub_cin};
    assign sub_half = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, sub_cin};

    assign inc_val = v + 8'd1;
    assign dec_val = v - 8'd1;

    assign hl_sum  = {1'b0, req.base_word} + {1'b0, req.addend_word};
    assign hl_half = {1'b0, req.base_word[11:0]} + {1'b0, req.addend_word[11:0]};

    // sp plus offset: flags from the unsigned low-byte add
    assign sp_sum  = req.base_word + {{8{req.offset[7]}}, req.offset};
    assign sp_half = {1'b0, req.base_word[3:0]} + {1'b0, req.offset[3:0]};
    assign sp_low  = {1'b0, req.base_word[7:0]} + {1'b0, req.offset};

    assign daa_lo   = fi[FLAG_H] | (~fi[FLAG_N] & (a[3:0] > DAA_NIB_MAX));
    assign daa_hi   = fi[FLAG_C] | (~fi[FLAG_N] & (a > DAA_BCD_MAX));
    assign daa_corr = (daa_lo ? DAA_LOW_FIX : 8'd0) | (daa_hi ? DAA_HIGH_FIX : 8'd0);
    assign daa_val  = fi[FLAG_N] ? (a - daa_corr) : (a + daa_corr);

    assign rot_src  = (req.req_type < OP_RLC) ? a : v;
    assign bit_mask = 8'd1 << req.bit_index;

    always_comb begin
        case (req.req_type[1:0])
            ROT_LC: begin
                rot_co  = rot_src[7];
                rot_val = {rot_src[6:0], rot_src[7]};
            end
            ROT_RC: begin
                rot_co  = rot_src[0];
                rot_val = {rot_src[0], rot_src[7:1]};
            end
            ROT_L: begin
                rot_co  = rot_src[7];
                rot_val = {rot_src[6:0], cin};
            end
            default: begin
                rot_co  = rot_src[0];
                rot_val = {cin, rot_src[7:1]};
            end
        endcase
    end

    always_comb begin
        res.acc_out     = a;
        res.flags_out   = fi;
        res.byte_result = 8'd0;
        res.word_result = 16'd0;
        unique case (req.req_type)
            OP_ADD, OP_ADC: begin
                res.acc_out   = add_sum[7:0];
                res.flags_out = {add_sum[7:0] == 8'd0, 1'b0, add_half[4], add_sum[8]};
            end
            OP_SUB, OP_SBC: begin
                res.acc_out   = sub_diff[7:0];
                res.flags_out = {sub_diff[7:0] == 8'd0, 1'b1, sub_half[4], sub_diff[8]};
            end
            OP_CP: begin
                res.flags_out = {sub_diff[7:0] == 8'd0, 1'b1, sub_half[4], sub_diff[8]};
            end
            OP_AND: begin
                res.acc_out   = a & v;
                res.flags_out = {(a & v) == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            OP_XOR: begin
                res.acc_out   = a ^ v;
                res.flags_out = {(a ^ v) == 8'd0, 3'b000};
            end
            OP_OR: begin
                res.acc_out   = a | v;
                res.flags_out = {(a | v) == 8'd0, 3'b000};
            end
            OP_INC: begin
                res.byte_result = inc_val;
                res.flags_out   = {inc_val == 8'd0, 1'b0, v[3:0] == 4'hF, cin};
            end
            OP_DEC: begin
                res.byte_result = dec_val;
                res.flags_out   = {dec_val == 8'd0, 1'b1, v[3:0] == 4'h0, cin};
            end
            OP_ADD_HL: begin
                res.word_result = hl_sum[15:0];
                res.flags_out   = {fi[FLAG_Z], 1'b0, hl_half[12], hl_sum[16]};
            end
            OP_ADD_SP: begin
                res.word_result = sp_sum;
                res.flags_out   = {2'b00, sp_half[4], sp_low[8]};
            end
            OP_DAA: begin
                res.acc_out   = daa_val;
                res.flags_out = {daa_val == 8'd0, fi[FLAG_N], 1'b0, daa_hi};
            end
            OP_CPL: begin
                res.acc_out   = ~a;
                res.flags_out = {fi[FLAG_Z], 1'b1, 1'b1, cin};
            end
            OP_SCF: res.flags_out = {fi[FLAG_Z], 2'b00, 1'b1};
            OP_CCF: res.flags_out = {fi[FLAG_Z], 2'b00, ~cin};
            OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
                // accumulator rotates always clear z
                res.acc_out     = rot_val;
                res.byte_result = rot_val;
                res.flags_out   = {3'b000, rot_co};
            end
            OP_RLC, OP_RRC, OP_RL, OP_RR: begin
                res.byte_result = rot_val;
                res.flags_out   = {rot_val == 8'd0, 2'b00, rot_co};
            end
            OP_SLA: begin
                res.byte_result = {v[6:0], 1'b0};
                res.flags_out   = {v[6:0] == 7'd0, 2'b00, v[7]};
            end
            OP_SRA: begin
                res.byte_result = {v[7], v[7:1]};
                res.flags_out   = {v[7:1] == 7'd0, 2'b00, v[0]};
            end
            OP_SWAP: begin
                res.byte_result = {v[3:0], v[7:4]};
                res.flags_out   = {v == 8'd0, 3'b000};
            end
            OP_SRL: begin
                res.byte_result = {1'b0, v[7:1]};
                res.flags_out   = {v[7:1] == 7'd0, 2'b00, v[0]};
            end
            OP_BIT: res.flags_out = {(v & bit_mask) == 8'd0, 1'b0, 1'b1, cin};
            OP_SET: begin
                res.byte_result = v | bit_mask;
                res.flags_out   = fi;
            end
            OP_RES: begin
                res.byte_result = v & ~bit_mask;
                res.flags_out   = fi;
            end
            // unused code: pass accumulator and flags through
            default: res.flags_out = fi;
        endcase
    end

endmodule

/* rtl/eight_bit_cpu_alu_with_flags_top.sv */
`timescale 1ns / 1ps
// top level of the eight-bit alu with flags: request register, datapath, result register
// depends on ebcalu_pkg and ebcalu_core
//
//  channel | dir | tdata fields (low bit up)                          | tuser
//  --------+-----+-----------------------------------------------------+---------
//  s_      | in  | acc_in, flags_in, operand_byte, base_word,          | req_type
//          |     | addend_word, offset, bit_index, zero pad to 64      |
//  m_      | out | acc_out, flags_out, byte_result, word_result,       | -
//          |     | zero pad to 40                                      |
//
// one request per cycle sustained when m_tready is high; requests pass both registers
// the datapath is one combinational pass between the request and result registers
// synchronous active-low reset empties both registers; payload is not reset
// a stalled m_ side holds the result; the request register still fills behind it,
// and s_tready drops only when both registers are full and m_tready is low
module eight_bit_cpu_alu_with_flags_top import ebcalu_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [7:0] acc_in, [11:8] flags_in, [19:12] operand_byte, [35:20] base_word,
    // [51:36] addend_word, [59:52] offset, [62:60] bit_index, [63] zero
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    // [4:0] req_type
    input  logic [4:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] acc_out, [11:8] flags_out, [19:12] byte_result, [35:20] word_result,
    // [39:36] zero
    output logic [TDATA_OUT_W-1:0] m_tdata
);

    logic in_valid_reg, in_valid_next;
    req_t in_req_reg;
    logic m_valid_reg, m_valid_next;
    res_t out_res_reg;
    res_t alu_res;
    req_t s_req;
    logic s_fire;
    logic out_load;

    // unpack the incoming request
    always_comb begin
        s_req.req_type     = op_t'(s_tuser);
        s_req.acc_in       = s_tdata[7:0];
        s_req.flags_in     = s_tdata[11:8];
        s_req.operand_byte = s_tdata[19:12];
        s_req.base_word    = s_tdata[35:20];
        s_req.addend_word  = s_tdata[51:36];
        s_req.offset       = s_tdata[59:52];
        s_req.bit_index    = s_tdata[62:60];
    end

    // result register takes the datapath output when empty or being drained
    assign out_load = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    ebcalu_core u_core (
        .req (in_req_reg),
        .res (alu_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_req_reg <= s_req;
        end
        if (out_load) begin
            out_res_reg <= alu_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, out_res_reg.word_result, out_res_reg.byte_result,
                       out_res_reg.flags_out, out_res_reg.acc_out};

    // a result moved forward is offered on the next cycle
    a_load_shows : assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg)
        else $error("loaded result not offered");

    // a held request is never dropped while the result side is stalled
    a_req_kept : assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_load) |=> in_valid_reg)
        else $error("pending request lost");

    // backpressure only when both registers are full and the sink stalls
    a_ready_cause : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && m_valid_reg && !m_tready))
        else $error("request side stalled without cause");

    // reset leaves both registers empty
    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> (!in_valid_reg && !m_valid_reg))
        else $error("registers not empty after reset");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// self-checking bench for eight_bit_cpu_alu_with_flags_top: directed table, then random requests
// depends on ebcalu_pkg and the rtl top level; needs nothing else

module tb_top;
    import ebcalu_pkg::*;

    // the only code the package enum leaves out: passes acc and flags straight through
    localparam logic [4:0] OP_UNDEF = 5'd31;
    localparam int CYCLE_LIMIT      = 250_000;
    localparam int RANDOM_PER_PHASE = 440;

    // a directed row: request plus, where it is obvious, the result typed in by hand
    typedef struct {
        req_t q;
        bit   typed;
        res_t want;
    } vec_row_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata  = '0;
    logic [4:0]             s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;

    res_t     results_due[$];
    res_t     next_result;
    vec_row_t vec_tab[$];
    int       reqs_taken   = 0;
    int       results_seen = 0;
    int       mismatches   = 0;
    int       cycle_cnt    = 0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;

    eight_bit_cpu_alu_with_flags_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // what the alu should return for one request; flags are built as {z, n, h, c}
    function automatic res_t alu_predict(input req_t q);
        res_t       o;
        logic [7:0] a, v, fix, src, r, off;
        logic [8:0] s9;
        logic [4:0] s5;
        logic [16:0] s17;
        logic [12:0] s13;
        logic       ci, cu, co, sub_mode, fix_c;
        a  = q.acc_in;
        v  = q.operand_byte;
        ci = q.flags_in[FLAG_C];
        off = q.offset;
        o.acc_out     = a;
        o.flags_out   = q.flags_in;
        o.byte_result = '0;
        o.word_result = '0;
        case (q.req_type)
            OP_ADD, OP_ADC: begin
                cu = (q.req_type == OP_ADC) ? ci : 1'b0;
                s9 = {1'b0, a} + {1'b0, v} + {8'd0, cu};
                s5 = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cu};
                o.acc_out   = s9[7:0];
                o.flags_out = {s9[7:0] == 8'd0, 1'b0, s5[4], s9[8]};
            end
            OP_SUB, OP_SBC, OP_CP: begin
                // borrow out of bit 8 / bit 4 gives c and h
                cu = (q.req_type == OP_SBC) ? ci : 1'b0;
                s9 = {1'b0, a} - {1'b0, v} - {8'd0, cu};
                s5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cu};
                if (q.req_type != OP_CP) o.acc_out = s9[7:0];
                o.flags_out = {s9[7:0] == 8'd0, 1'b1, s5[4], s9[8]};
            end
            OP_AND: begin
                o.acc_out   = a & v;
                o.flags_out = {(a & v) == 8'd0, 3'b010};
            end
            OP_XOR: begin
                o.acc_out   = a ^ v;
                o.flags_out = {(a ^ v) == 8'd0, 3'b000};
            end
            OP_OR: begin
                o.acc_out   = a | v;
                o.flags_out = {(a | v) == 8'd0, 3'b000};
            end
            OP_INC: begin
                o.byte_result = v + 8'd1;
                o.flags_out   = {o.byte_result == 8'd0, 1'b0, v[3:0] == 4'hF, ci};
            end
            OP_DEC: begin
                o.byte_result = v - 8'd1;
                o.flags_out   = {o.byte_result == 8'd0, 1'b1, v[3:0] == 4'h0, ci};
            end
            OP_ADD_HL: begin
                s17 = {1'b0, q.base_word} + {1'b0, q.addend_word};
                s13 = {1'b0, q.base_word[11:0]} + {1'b0, q.addend_word[11:0]};
                o.word_result = s17[15:0];
                o.flags_out   = {q.flags_in[FLAG_Z], 1'b0, s13[12], s17[16]};
            end
            OP_ADD_SP: begin
                // h and c from the unsigned low-byte add, whatever the sign
                o.word_result = q.base_word + {{8{off[7]}}, off};
                s5 = {1'b0, q.base_word[3:0]} + {1'b0, off[3:0]};
                s9 = {1'b0, q.base_word[7:0]} + {1'b0, off};
                o.flags_out = {2'b00, s5[4], s9[8]};
            end
            OP_DAA: begin
                sub_mode = q.flags_in[FLAG_N];
                fix   = '0;
                fix_c = 1'b0;
                if (q.flags_in[FLAG_H] || (!sub_mode && a[3:0] > DAA_NIB_MAX))
                    fix = fix | DAA_LOW_FIX;
                if (ci || (!sub_mode && a > DAA_BCD_MAX)) begin
                    fix   = fix | DAA_HIGH_FIX;
                    fix_c = 1'b1;
                end
                o.acc_out   = sub_mode ? a - fix : a + fix;
                o.flags_out = {o.acc_out == 8'd0, sub_mode, 1'b0, fix_c};
            end
            OP_CPL: begin
                o.acc_out   = ~a;
                o.flags_out = q.flags_in | 4'b0110;
            end
            OP_SCF: o.flags_out = {q.flags_in[FLAG_Z], 3'b001};
            OP_CCF: o.flags_out = {q.flags_in[FLAG_Z], 2'b00, ~ci};
            OP_RLCA, OP_RRCA, OP_RLA, OP_RRA, OP_RLC, OP_RRC, OP_RL, OP_RR: begin
                src = (q.req_type < OP_RLC) ? a : v;
                case (q.req_type[1:0])
                    ROT_LC: begin
                        co = src[7];
                        r  = {src[6:0], src[7]};
                    end
                    ROT_RC: begin
                        co = src[0];
                        r  = {src[0], src[7:1]};
                    end
                    ROT_L: begin
                        co = src[7];
                        r  = {src[6:0], ci};
                    end
                    default: begin
                        co = src[0];
                        r  = {ci, src[7:1]};
                    end
                endcase
                o.byte_result = r;
                // accumulator forms always clear z
                if (q.req_type < OP_RLC) begin
                    o.acc_out   = r;
                    o.flags_out = {3'b000, co};
                end else begin
                    o.flags_out = {r == 8'd0, 2'b00, co};
                end
            end
            OP_SLA: begin
                o.byte_result = {v[6:0], 1'b0};
                o.flags_out   = {o.byte_result == 8'd0, 2'b00, v[7]};
            end
            OP_SRA: begin
                o.byte_result = {v[7], v[7:1]};
                o.flags_out   = {o.byte_result == 8'd0, 2'b00, v[0]};
            end
            OP_SWAP: begin
                o.byte_result = {v[3:0], v[7:4]};
                o.flags_out   = {o.byte_result == 8'd0, 3'b000};
            end
            OP_SRL: begin
                o.byte_result = {1'b0, v[7:1]};
                o.flags_out   = {o.byte_result == 8'd0, 2'b00, v[0]};
            end
            OP_BIT: o.flags_out = {~v[q.bit_index], 2'b01, ci};
            OP_SET: o.byte_result = v | (8'd1 << q.bit_index);
            OP_RES: o.byte_result = v & ~(8'd1 << q.bit_index);
            default: ;
        endcase
        return o;
    endfunction

    function automatic req_t mk_req(input logic [4:0] op, input logic [7:0] a,
                                    input logic [3:0] fl, input logic [7:0] v,
                                    input logic [15:0] b, input logic [15:0] ad,
                                    input logic [7:0] off, input logic [2:0] bi);
        req_t q;
        q.req_type     = op_t'(op);
        q.acc_in       = a;
        q.flags_in     = fl;
        q.operand_byte = v;
        q.base_word    = b;
        q.addend_word  = ad;
        q.offset       = off;
        q.bit_index    = bi;
        return q;
    endfunction

    // rows checked by the predictor
    function automatic vec_row_t row_pred(input req_t q);
        vec_row_t w;
        w.q     = q;
        w.typed = 1'b0;
        w.want  = '0;
        return w;
    endfunction

    // rows whose result is typed in
    function automatic vec_row_t row_fixed(input req_t q, input logic [7:0] acc,
                                           input logic [3:0] fl, input logic [7:0] bres,
                                           input logic [15:0] wres);
        vec_row_t w;
        w.q     = q;
        w.typed = 1'b1;
        w.want  = '{acc_out: acc, flags_out: fl, byte_result: bres, word_result: wres};
        return w;
    endfunction

    // bytes near the carry, half-carry and bcd boundaries turn up often
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(11))
            0: return 8'h00;
            1: return 8'hFF;
            2: return {4'($urandom), 4'hF};
            3: return 8'h80 | 8'($urandom_range(1));
            4: return 8'h99 + 8'($urandom_range(1));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(9))
            0: return 16'hFFFF;
            1: return 16'h0FFF;
            2: return 16'h0000;
            3: return {8'($urandom), 8'hFF};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
        mismatches++;
    endtask

    // hands one request to the block; valid stays high until it is taken
    task automatic send_request(input req_t q, input res_t want);
        int taken_before;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        next_result = want;
        s_tvalid <= 1'b1;
        s_tuser  <= q.req_type;
        s_tdata  <= {1'b0, q.bit_index, q.offset, q.addend_word, q.base_word,
                     q.operand_byte, q.flags_in, q.acc_in};
        taken_before = reqs_taken;
        do @(negedge aclk); while (reqs_taken == taken_before);
    endtask

    // receiver back-pressure, changed at the falling edge
    always @(negedge aclk) begin
        if (aresetn)
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // sample both channels at the rising edge: book accepted requests, check results
    always @(posedge aclk) begin
        res_t got, want;
        cycle_cnt++;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                results_due.push_back(next_result);
                reqs_taken++;
            end
            if (m_tvalid && m_tready) begin
                got.acc_out     = m_tdata[7:0];
                got.flags_out   = m_tdata[11:8];
                got.byte_result = m_tdata[19:12];
                got.word_result = m_tdata[35:20];
                results_seen++;
                if (results_due.size() == 0) begin
                    report_mismatch("unrequested result", 0, int'(m_tdata[31:0]));
                end else begin
                    want = results_due.pop_front();
                    if (got.acc_out != want.acc_out)
                        report_mismatch("acc_out", int'(want.acc_out), int'(got.acc_out));
                    if (got.flags_out != want.flags_out)
                        report_mismatch("flags_out", int'(want.flags_out),
                                        int'(got.flags_out));
                    if (got.byte_result != want.byte_result)
                        report_mismatch("byte_result", int'(want.byte_result),
                                        int'(got.byte_result));
                    if (got.word_result != want.word_result)
                        report_mismatch("word_result", int'(want.word_result),
                                        int'(got.word_result));
                end
            end
        end
        // watchdog
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $realtime,
                     results_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        req_t q;
        res_t want;
        int   phase_stall [4];
        int   phase_idle  [4];

        phase_stall = '{0, 0, 47, 11};
        phase_idle  = '{0, 47, 0, 11};

        // directed table: at least one row per code, extremes and the flag quirks
        // flags columns below read z n h c
        vec_tab.push_back(row_fixed(mk_req(OP_ADD, 8'hFF, 4'b0000, 8'h01, 0, 0, 0, 0),
                                    8'h00, 4'b1011, 8'h00, 16'h0000));
        vec_tab.push_back(row_fixed(mk_req(OP_ADC, 8'h0F, 4'b0001, 8'h00, 0, 0, 0, 0),
                                    8'h10, 4'b0010, 8'h00, 16'h0000));
        vec_tab.push_back(row_fixed(mk_req(OP_SUB, 8'h00, 4'b0000, 8'h01, 0, 0, 0, 0),
                                    8'hFF, 4'b0111, 8'h00, 16'h0000));
        vec_tab.push_back(row_pred(mk_req(OP_SBC, 8'h00, 4'b0001, 8'hFF, 0, 0, 0, 0)));
        vec_tab.push_back(row_fixed(mk_req(OP_AND, 8'hF0, 4'b0000, 8'h0F, 0, 0, 0, 0),
                                    8'h00, 4'b1010, 8'h00, 16'h0000));
        vec_tab.push_back(row_fixed(mk_req(OP_XOR, 8'hFF, 4'b0111, 8'hFF, 0, 0, 0, 0),
                                    8'h00, 4'b1000, 8'h00, 16'h0000));
        vec_tab.push_back(row_fixed(mk_req(OP_OR, 8'h00, 4'b1111, 8'h80, 0, 0, 0, 0),
                                    8'h80, 4'b0000, 8'h00, 16'h0000));
        vec_tab.push_back(row_fixed(mk_req(OP_CP, 8'h42, 4'b0000, 8'h42, 0, 0, 0, 0),
                                    8'h42, 4'b1100, 8'h00, 16'h0000));
        // inc and dec keep the incoming carry
        vec_tab.push_back(row_fixed(mk_req(OP_INC, 8'h12, 4'b0001, 8'hFF, 0, 0, 0, 0),
                                    8'h12, 4'b1011, 8'h00, 16'h0000));
        vec_tab.push_back(row_fixed(mk_req(OP_DEC, 8'h34, 4'b0000, 8'h00, 0, 0, 0, 0),
                                    8'h34, 4'b0110, 8'hFF, 16'h0000));
        // 16-bit hl add keeps z
        vec_tab.push_back(row_fixed(mk_req(OP_ADD_HL, 8'h00, 4'b1000, 8'h00,
                                           16'hFFFF, 16'h0001, 0, 0),
                                    8'h00, 4'b1011, 8'h00, 16'h0000));
        vec_tab.push_back(row_pred(mk_req(OP_ADD_HL, 8'h00, 4'b0111, 8'h00,
                                          16'h0FFF, 16'hF001, 0, 0)));
        // sp plus negative and positive offsets, carries from the low byte
        vec_tab.push_back(row_pred(mk_req(OP_ADD_SP, 8'h00, 4'b1111, 8'h00,
                                          16'h00FF, 16'h0000, 8'hFF, 0)));
        vec_tab.push_back(row_pred(mk_req(OP_ADD_SP, 8'h00, 4'b0000, 8'h00,
                                          16'hFFF0, 16'h0000, 8'h7F, 0)));
        vec_tab.push_back(row_pred(mk_req(OP_ADD_SP, 8'h00, 4'b0000, 8'h00,
                                          16'h0000, 16'hFFFF, 8'h80, 0)));
        // decimal adjust after add and after subtract
        vec_tab.push_back(row_pred(mk_req(OP_DAA, 8'h9A, 4'b0000, 8'h00, 0, 0, 0, 0)));
        vec_tab.push_back(row_pred(mk_req(OP_DAA, 8'h00, 4'b0111, 8'h00, 0, 0, 0, 0)));
        vec_tab.push_back(row_fixed(mk_req(OP_CPL, 8'h55, 4'b0000, 8'h00, 0, 0, 0, 0),
                                    8'hAA, 4'b0110, 8'h00, 16'h0000));
        vec_tab.push_back(row_fixed(mk_req(OP_SCF, 8'h00, 4'b1110, 8'h00, 0, 0, 0, 0),
                                    8'h00, 4'b1001, 8'h00, 16'h0000));
        vec_tab.push_back(row_fixed(mk_req(OP_CCF, 8'h00, 4'b1001, 8'h00, 0, 0, 0, 0),
                                    8'h00, 4'b1000, 8'h00, 16'h0000));
        // accumulator rotates: result to acc and byte, z cleared even on zero
        vec_tab.push_back(row_fixed(mk_req(OP_RLCA, 8'h80, 4'b1000, 8'h00, 0, 0, 0, 0),
                                    8'h01, 4'b0001, 8'h01, 16'h0000));
        vec_tab.push_back(row_pred(mk_req(OP_RRCA, 8'h01, 4'b0000, 8'h00, 0, 0, 0, 0)));
        vec_tab.push_back(row_pred(mk_req(OP_RLA, 8'h80, 4'b0000, 8'h00, 0, 0, 0, 0)));
        vec_tab.push_back(row_fixed(mk_req(OP_RRA, 8'h01, 4'b0000, 8'h00, 0, 0, 0, 0),
                                    8'h00, 4'b0001, 8'h00, 16'h0000));
        vec_tab.push_back(row_pred(mk_req(OP_RLC, 8'h11, 4'b0000, 8'h00, 0, 0, 0, 0)));
        vec_tab.push_back(row_pred(mk_req(OP_RRC, 8'h22, 4'b0000, 8'h01, 0, 0, 0, 0)));
        vec_tab.push_back(row_fixed(mk_req(OP_RL, 8'h33, 4'b0000, 8'h80, 0, 0, 0, 0),
                                    8'h33, 4'b1001, 8'h00, 16'h0000));
        vec_tab.push_back(row_pred(mk_req(OP_RR, 8'h44, 4'b0001, 8'h01, 0, 0, 0, 0)));
        vec_tab.push_back(row_pred(mk_req(OP_SLA, 8'h00, 4'b0000, 8'h80, 0, 0, 0, 0)));
        vec_tab.push_back(row_pred(mk_req(OP_SRA, 8'h00, 4'b0000, 8'h81, 0, 0, 0, 0)));
        vec_tab.push_back(row_pred(mk_req(OP_SWAP, 8'h00, 4'b1111, 8'hF0, 0, 0, 0, 0)));
        vec_tab.push_back(row_pred(mk_req(OP_SRL, 8'h00, 4'b0000, 8'h01, 0, 0, 0, 0)));
        vec_tab.push_back(row_fixed(mk_req(OP_BIT, 8'h00, 4'b0001, 8'h7F, 0, 0, 0, 3'd7),
                                    8'h00, 4'b1011, 8'h00, 16'h0000));
        vec_tab.push_back(row_fixed(mk_req(OP_SET, 8'h00, 4'b0101, 8'h00, 0, 0, 0, 3'd7),
                                    8'h00, 4'b0101, 8'h80, 16'h0000));
        vec_tab.push_back(row_pred(mk_req(OP_RES, 8'h00, 4'b0000, 8'hFF, 0, 0, 0, 3'd0)));
        // undefined code passes acc and flags through
        vec_tab.push_back(row_fixed(mk_req(OP_UNDEF, 8'hA5, 4'b1010, 8'hFF,
                                           16'hFFFF, 16'hFFFF, 8'hFF, 3'd7),
                                    8'hA5, 4'b1010, 8'h00, 16'h0000));

        // reset held low from the start, released on a falling edge
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part, no idling on either side
        foreach (vec_tab[i]) begin
            want = vec_tab[i].typed ? vec_tab[i].want : alu_predict(vec_tab[i].q);
            send_request(vec_tab[i].q, want);
        end

        // random part in four idling phases; no configuration, so no pause between them
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = phase_idle[ph];
            recv_stall_pct = phase_stall[ph];
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                q = mk_req(5'($urandom_range(31)), pick_byte(), 4'($urandom), pick_byte(),
                           pick_word(), pick_word(), pick_byte(), 3'($urandom));
                send_request(q, alu_predict(q));
            end
        end
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;

        // drain, then let the last result clear the request and result registers
        while (results_due.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("%0d requests (%0d directed) over four idling phases, %0d results checked",
                 reqs_taken, vec_tab.size(), results_seen);
        $display("%0d field mismatches, %0d results still expected", mismatches,
                 results_due.size());
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
